### design/assert_macros.svh
// Assertion macros shared by the checker file of the ring averager.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on i_clk, quiet while i_rst_n is low.
`define IARAV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Concurrent check on i_clk that also holds across reset.
`define IARAV_ASSERT_NORST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

### design/iarav_pkg.sv
// Package with the shared widths, codes and state type of the ring averager.
`timescale 1ns / 1ps

package iarav_pkg;

    localparam int WORD_W    = 16;
    localparam int SAMPLE_W  = 12;
    localparam int CHAN_W    = 4;
    localparam int WIN_W     = 6;
    localparam int CFG_W     = 5;
    // Sum of up to 63 twelve-bit samples.
    localparam int SUM_W     = 18;
    // Divisor holds either a window size or a channel count.
    localparam int DIVISOR_W = 6;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = 12'h0fff;

    localparam logic ACT_STORE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_NORM  = 7'b0000100,
        S_MOD   = 7'b0001000,
        S_WALK  = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

endpackage

### design/iarav_in_if.sv
// Input channel interface: store or query transaction.
`timescale 1ns / 1ps

interface iarav_in_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [iarav_pkg::WORD_W-1:0]  sample_word;
    logic [iarav_pkg::CHAN_W-1:0]  query_channel;
    logic [iarav_pkg::WIN_W-1:0]   window_size;

    modport source (output valid, action, sample_word, query_channel, window_size,
                    input ready);
    modport sink   (input valid, action, sample_word, query_channel, window_size,
                    output ready);
endinterface

### design/iarav_out_if.sv
// Result channel interface: channel average and bad-channel flag.
`timescale 1ns / 1ps

interface iarav_out_if;
    logic                           valid;
    logic                           ready;
    logic [iarav_pkg::SAMPLE_W-1:0] average;
    logic                           bad_channel;

    modport source (output valid, average, bad_channel, input ready);
    modport sink   (input valid, average, bad_channel, output ready);
endinterface

### design/iarav_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module iarav_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 512
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/iarav_div.sv
// Restoring divider: one quotient bit per cycle, quotient and remainder out.
`timescale 1ns / 1ps

module iarav_div #(
    parameter int DIVIDEND_W = 18,
    parameter int DIVISOR_W  = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient,
    output logic [DIVISOR_W-1:0]  o_remainder
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [DIVIDEND_W-1:0] r_quo, n_quo;
    logic [DIVISOR_W-1:0]  r_rem, n_rem;
    logic [DIVISOR_W-1:0]  r_div, n_div;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    // Trial subtract of the divisor from the shifted partial remainder
    assign trial = {r_rem, r_quo[DIVIDEND_W-1]};
    assign fits  = (trial >= {1'b0, r_div});
    assign diff  = trial - {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DIVIDEND_W);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[DIVIDEND_W-2:0], fits};
            n_rem = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control flags cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

### design/interleaved_adc_ring_averager_top.sv
// Top level of the interleaved converter ring with per-channel averaging.
//
// Channels: i_in carries store and query transactions (valid/ready),
// o_res carries one result per query (valid/ready); a store gives none.
// i_cfg_we/i_cfg_wdata write the channel count, saturated to 1..MAX_CHANNELS;
// write it only while the block is idle.
// A store is written in S_NORM before the next transaction is accepted; after a
// channel count change the stored pointer is reduced by repeated subtraction of
// the ring size. A query runs the shared bit-serial divider once for the slot
// phase (newest slot mod channel count) and once for the mean, and the ring walk
// reads one slot per cycle from the single read port of the ring memory.
// A bad channel or a zero window goes from S_NORM straight to S_OUT.
// Reset (synchronous, active low) starts a clearing pass that writes zero to
// every ring slot (MAX_CHANNELS * SAMPLES_PER_CHANNEL, 512 at the defaults),
// with i_in.ready low; the channel count returns to 1.
// A finished result sits in the output register; the next transaction is
// accepted while it waits, and a query that finishes before it is taken
// holds until the output register frees.
`timescale 1ns / 1ps

module interleaved_adc_ring_averager_top #(
    parameter int SAMPLES_PER_CHANNEL = 32,
    parameter int MAX_CHANNELS        = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [iarav_pkg::CFG_W-1:0]  i_cfg_wdata,
    iarav_in_if.sink                     i_in,
    iarav_out_if.source                  o_res
);

    localparam int SLOTS  = MAX_CHANNELS * SAMPLES_PER_CHANNEL;
    localparam int PTR_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SIZE_W = $clog2(SLOTS + 1);
    localparam int NW     = iarav_pkg::CFG_W;
    localparam int SW     = iarav_pkg::SAMPLE_W;
    localparam int SUM_W  = iarav_pkg::SUM_W;
    localparam int DVS_W  = iarav_pkg::DIVISOR_W;
    localparam int DIV_W  = (PTR_W > SUM_W) ? PTR_W : SUM_W;

    iarav_pkg::t_state r_state, n_state;

    logic [NW-1:0]                r_n, n_n;
    logic [SIZE_W-1:0]            r_size, n_size;
    logic [PTR_W-1:0]             r_wp, n_wp;
    logic [PTR_W-1:0]             r_wpm, n_wpm;
    logic [PTR_W-1:0]             r_clr, n_clr;
    logic [PTR_W-1:0]             r_last, n_last;
    logic [PTR_W-1:0]             r_slot, n_slot;
    logic [iarav_pkg::WIN_W-1:0]  r_left, n_left;
    logic                         r_pend, n_pend;
    logic [SUM_W-1:0]             r_sum, n_sum;
    logic                         r_out_valid, n_out_valid;
    logic [SW-1:0]                r_avg, n_avg;
    logic                         r_bad, n_bad;
    logic [SW-1:0]                r_res_avg, n_res_avg;
    logic                         r_res_bad, n_res_bad;

    logic                         r_act;
    logic [SW-1:0]                r_sample;
    logic [iarav_pkg::CHAN_W-1:0] r_chan;
    logic [iarav_pkg::WIN_W-1:0]  r_win;

    logic                         accept;
    logic [NW-1:0]                cfg_n;
    logic [SIZE_W-1:0]            n_ext;
    logic                         wpm_over;
    logic [SIZE_W-1:0]            wpm_inc;
    logic [PTR_W-1:0]             wp_adv;
    logic [PTR_W-1:0]             last;
    logic                         chan_bad;
    logic [SIZE_W-1:0]            base;
    logic [SIZE_W-1:0]            back;
    logic [SIZE_W-1:0]            first_slot;
    logic [SIZE_W-1:0]            step_slot;

    logic                         div_start;
    logic [DIV_W-1:0]             div_dividend;
    logic [DVS_W-1:0]             div_divisor;
    logic                         div_done;
    logic [DIV_W-1:0]             div_quo;
    logic [DVS_W-1:0]             div_rem;

    logic                         ram_we;
    logic [PTR_W-1:0]             ram_waddr;
    logic [SW-1:0]                ram_wdata;
    logic [SW-1:0]                ram_rdata;

    assign accept = i_in.valid && i_in.ready;

    // Saturate the written channel count to 1..MAX_CHANNELS
    always_comb begin
        priority if (i_cfg_wdata == '0) begin
            cfg_n = NW'(1);
        end else if (i_cfg_wdata > NW'(MAX_CHANNELS)) begin
            cfg_n = NW'(MAX_CHANNELS);
        end else begin
            cfg_n = i_cfg_wdata;
        end
    end

    // Pointer arithmetic on the ring of r_size slots
    assign n_ext    = SIZE_W'(r_n);
    assign wpm_over = (SIZE_W'(r_wpm) >= r_size);
    assign wpm_inc  = SIZE_W'(r_wpm) + SIZE_W'(1);
    assign wp_adv   = (wpm_inc >= r_size) ? '0 : wpm_inc[PTR_W-1:0];
    assign last     = (r_wpm == '0) ? PTR_W'(r_size - SIZE_W'(1)) : r_wpm - PTR_W'(1);
    assign chan_bad = (NW'(r_chan) >= r_n);

    // Newest slot of the channel: frame start of the last slot plus channel,
    // one frame back when the channel lies past the last slot
    assign base       = SIZE_W'(r_last) - SIZE_W'(div_rem);
    assign back       = (base >= n_ext) ? base - n_ext : base + r_size - n_ext;
    assign first_slot = (DVS_W'(r_chan) > div_rem) ? back + SIZE_W'(r_chan)
                                                   : base + SIZE_W'(r_chan);

    // Walk back one frame with wrap
    assign step_slot = (SIZE_W'(r_slot) >= n_ext) ? SIZE_W'(r_slot) - n_ext
                                                  : SIZE_W'(r_slot) + r_size - n_ext;

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_n          = r_n;
        n_size       = r_size;
        n_wp         = r_wp;
        n_wpm        = r_wpm;
        n_clr        = r_clr;
        n_last       = r_last;
        n_slot       = r_slot;
        n_left       = r_left;
        n_pend       = r_pend;
        n_sum        = r_sum;
        n_out_valid  = r_out_valid;
        n_avg        = r_avg;
        n_bad        = r_bad;
        n_res_avg    = r_res_avg;
        n_res_bad    = r_res_bad;
        div_start    = 1'b0;
        div_dividend = DIV_W'(last);
        div_divisor  = DVS_W'(r_n);
        ram_we       = 1'b0;
        ram_waddr    = r_wpm;
        ram_wdata    = r_sample;

        if (i_cfg_we) begin
            n_n    = cfg_n;
            n_size = SIZE_W'(cfg_n) * SIZE_W'(SAMPLES_PER_CHANNEL);
        end

        // Drop the output once the receiver takes it
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            iarav_pkg::S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                if (r_clr == PTR_W'(SLOTS - 1)) begin
                    n_state = iarav_pkg::S_IDLE;
                end else begin
                    n_clr = r_clr + PTR_W'(1);
                end
            end
            iarav_pkg::S_IDLE: begin
                if (accept) begin
                    n_wpm   = r_wp;
                    n_state = iarav_pkg::S_NORM;
                end
            end
            iarav_pkg::S_NORM: begin
                if (wpm_over) begin
                    n_wpm = PTR_W'(SIZE_W'(r_wpm) - r_size);
                end else if (r_act == iarav_pkg::ACT_STORE) begin
                    ram_we  = 1'b1;
                    n_wp    = wp_adv;
                    n_state = iarav_pkg::S_IDLE;
                end else if (chan_bad) begin
                    n_res_avg = '0;
                    n_res_bad = 1'b1;
                    n_state   = iarav_pkg::S_OUT;
                end else if (r_win == '0) begin
                    n_res_avg = '0;
                    n_res_bad = 1'b0;
                    n_state   = iarav_pkg::S_OUT;
                end else begin
                    n_last    = last;
                    div_start = 1'b1;
                    n_state   = iarav_pkg::S_MOD;
                end
            end
            iarav_pkg::S_MOD: begin
                if (div_done) begin
                    n_slot  = first_slot[PTR_W-1:0];
                    n_left  = r_win;
                    n_pend  = 1'b0;
                    n_sum   = '0;
                    n_state = iarav_pkg::S_WALK;
                end
            end
            iarav_pkg::S_WALK: begin
                // Issue one read per cycle and add each word in the next cycle, from the registered read port
                if (r_left != '0) begin
                    n_slot = step_slot[PTR_W-1:0];
                    n_left = r_left - iarav_pkg::WIN_W'(1);
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    n_sum = r_sum + SUM_W'(ram_rdata);
                end
                if (r_left == '0 && !r_pend) begin
                    div_start    = 1'b1;
                    div_dividend = DIV_W'(r_sum);
                    div_divisor  = DVS_W'(r_win);
                    n_state      = iarav_pkg::S_DIV;
                end
            end
            iarav_pkg::S_DIV: begin
                if (div_done) begin
                    n_res_avg = div_quo[SW-1:0] & iarav_pkg::SAMPLE_MASK;
                    n_res_bad = 1'b0;
                    n_state   = iarav_pkg::S_OUT;
                end
            end
            iarav_pkg::S_OUT: begin
                // Hold until the output register is free
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_avg       = r_res_avg;
                    n_bad       = r_res_bad;
                    n_state     = iarav_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = iarav_pkg::S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= iarav_pkg::S_CLEAR;
            r_n         <= NW'(1);
            r_size      <= SIZE_W'(SAMPLES_PER_CHANNEL);
            r_wp        <= '0;
            r_clr       <= '0;
            r_left      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_n         <= n_n;
            r_size      <= n_size;
            r_wp        <= n_wp;
            r_clr       <= n_clr;
            r_left      <= n_left;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_wpm     <= n_wpm;
        r_last    <= n_last;
        r_slot    <= n_slot;
        r_sum     <= n_sum;
        r_avg     <= n_avg;
        r_bad     <= n_bad;
        r_res_avg <= n_res_avg;
        r_res_bad <= n_res_bad;
        if (accept) begin
            r_act    <= i_in.action;
            r_sample <= i_in.sample_word[SW-1:0] & iarav_pkg::SAMPLE_MASK;
            r_chan   <= i_in.query_channel;
            r_win    <= i_in.window_size;
        end
    end

    iarav_ram #(
        .WIDTH (SW),
        .DEPTH (SLOTS)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_slot),
        .o_rdata (ram_rdata)
    );

    iarav_div #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (DVS_W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    assign i_in.ready        = (r_state == iarav_pkg::S_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.average     = r_avg;
    assign o_res.bad_channel = r_bad;

endmodule

### design/iarav_chk.sv
// Port checker for the ring averager and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module iarav_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [iarav_pkg::SAMPLE_W-1:0] i_out_average,
    input logic                           i_out_bad_channel
);

    // A stalled result stays offered and unchanged
    `IARAV_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid, "result dropped while stalled")
    `IARAV_ASSERT(a_out_stable, i_out_valid && !i_out_ready |=> $stable(i_out_average) && $stable(i_out_bad_channel), "result changed while stalled")

    // A flagged channel reports a zero average
    `IARAV_ASSERT(a_bad_zero, i_out_valid && i_out_bad_channel |-> i_out_average == '0, "bad channel with nonzero average")

    // Each transaction is worked alone: no acceptance in the cycle after one
    `IARAV_ASSERT(a_one_at_a_time, i_in_valid && i_in_ready |=> !i_in_ready, "transaction accepted during work")

    // Reset starts the clearing pass with the input closed
    `IARAV_ASSERT_NORST(a_clear_after_reset, !i_rst_n |=> !i_in_ready, "input open right after reset")

endmodule

bind interleaved_adc_ring_averager_top iarav_chk u_iarav_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_res.valid),
    .i_out_ready       (o_res.ready),
    .i_out_average     (o_res.average),
    .i_out_bad_channel (o_res.bad_channel)
);
